// ===== rtl/svdbs_pkg.sv =====
`timescale 1ns / 1ps
// svdbs_pkg: shared constants, codes, state type and saturating helper
// for the svd back-substitution solve unit; no dependencies

package svdbs_pkg;

  localparam int MAX_ROWS_DEF  = 8;
  localparam int NUM_TERMS_DEF = 4;

  localparam int CMD_W      = 2;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 2;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 64;
  localparam int TIDX_W     = 2;
  localparam int NROWS_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NROWS_RST = 8;

  localparam int DIV_STEPS = 64;

  localparam logic [CMD_W-1:0] CMD_LOAD_U = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_V = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_W = 2'd2;
  localparam logic [CMD_W-1:0] CMD_B_ELEM = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_N_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_VAL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ACC,
    S_ROWEND,
    S_ERR,
    S_DIV_START,
    S_DIV_WAIT,
    S_V_RD,
    S_V_MUL,
    S_V_ACC,
    S_OUT
  } svdbs_state_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/svdbs_ram.sv =====
`timescale 1ns / 1ps
// svdbs_ram: generic single-write, single-read ram with registered read
// depends on nothing

module svdbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/svdbs_div.sv =====
`timescale 1ns / 1ps
// svdbs_div: bit-serial signed 64 / 32 divider, truncating, result saturated to 32 bits
// depends on svdbs_pkg

module svdbs_div import svdbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic signed [VAL_W-1:0] divisor,
  output logic                    done,
  output logic signed [VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [ACC_W-1:0]   dq_r;
  logic [VAL_W-1:0]   rem_r;
  logic [VAL_W-1:0]   dvs_r;

  logic [VAL_W:0]     rem_sh;
  logic [VAL_W:0]     diff;
  logic               ge;
  logic               q_big;

  assign rem_sh = {rem_r, dq_r[ACC_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[ACC_W-1] ^ divisor[VAL_W-1];
      dq_r  <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
      dvs_r <= divisor[VAL_W-1] ? (~divisor + VAL_W'(1)) : divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      dq_r  <= {dq_r[ACC_W-2:0], ge};
    end
  end

  // magnitude of 2^31 or more saturates
  assign q_big = |dq_r[ACC_W-1:VAL_W-1];

  always_comb begin
    if (neg_r) begin
      quotient = q_big ? {1'b1, {(VAL_W-1){1'b0}}} : (~dq_r[VAL_W-1:0] + VAL_W'(1));
    end else begin
      quotient = q_big ? {1'b0, {(VAL_W-1){1'b1}}} : dq_r[VAL_W-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/svd_backsubstitution_solve_unit.sv =====
`timescale 1ns / 1ps
// svd_backsubstitution_solve_unit: solves A x = b from stored U, V and W factors
// depends on svdbs_pkg, svdbs_ram, svdbs_div
//
// Load commands (U, V, W entries) never raise busy. A b element raises busy while
// one shared multiplier and saturating 64-bit adder walk the U row (address,
// multiply, accumulate per term); a skipped or excess element goes straight to
// the row-end state. After the last element's pass the length is checked: a
// mismatch gives one status=1 result in the next cycle. Otherwise the bit-serial
// divider runs once per nonzero w (a zero w gives a zero term), then the same
// multiplier and adder form V*u, with each term on out_valid for one cycle as it
// completes. Results cannot be held off by the receiver; out_valid marks each
// transfer.

module svd_backsubstitution_solve_unit import svdbs_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int NUM_TERMS = NUM_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic [CMD_W-1:0]             in_cmd,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [COL_W-1:0]             in_col,
  input  logic signed [VAL_W-1:0]      in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic [TIDX_W-1:0]            out_term_index,
  output logic signed [VAL_W-1:0]      out_term_value,
  output logic                         out_status,
  output logic                         out_last_term
);

  localparam int U_DEPTH = MAX_ROWS * NUM_TERMS;
  localparam int V_DEPTH = NUM_TERMS * NUM_TERMS;
  localparam int U_AW    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
  localparam int V_AW    = (V_DEPTH > 1) ? $clog2(V_DEPTH) : 1;
  localparam int J_W     = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
  localparam int RC_W    = $clog2(MAX_ROWS + 2);
  localparam logic [J_W-1:0] J_LAST = J_W'(NUM_TERMS - 1);

  svdbs_state_t state_r, state_nxt;

  logic [NROWS_W-1:0]      n_rows_r;
  logic                    miss_en_r;
  logic signed [VAL_W-1:0] miss_val_r;

  logic [J_W-1:0]          j_r;
  logic [J_W-1:0]          i_r;
  logic [J_W-1:0]          j_step;
  logic [RC_W-1:0]         rc_r;
  logic [RC_W-1:0]         rc_inc;
  logic                    last_r;
  logic signed [ACC_W-1:0] acc_r [NUM_TERMS];
  logic signed [VAL_W-1:0] w_r [NUM_TERMS];
  logic signed [VAL_W-1:0] term_r [NUM_TERMS];
  logic signed [VAL_W-1:0] b_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] sum_r;

  logic                    accept;
  logic                    accept_b;
  logic                    do_acc;
  logic                    len_err;
  logic                    w_zero;

  logic                    u_we;
  logic                    v_we;
  logic [31:0]             u_wa_full;
  logic [31:0]             v_wa_full;
  logic [31:0]             u_ra_full;
  logic [31:0]             v_ra_full;
  logic [VAL_W-1:0]        u_rdata;
  logic [VAL_W-1:0]        v_rdata;

  logic signed [VAL_W-1:0] mul_a;
  logic signed [VAL_W-1:0] mul_b;
  logic signed [ACC_W-1:0] mul_p;
  logic signed [ACC_W-1:0] add_a;
  logic signed [ACC_W-1:0] add_res;

  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_q;

  logic signed [ACC_W-1:0] sum_sh;
  logic signed [VAL_W-1:0] sum_sat;

  assign accept   = start && !busy;
  assign accept_b = accept && in_cmd == CMD_B_ELEM;
  assign do_acc   = !(miss_en_r && in_value == miss_val_r) && int'(rc_r) < MAX_ROWS;
  assign rc_inc   = (int'(rc_r) < MAX_ROWS + 1) ? rc_r + RC_W'(1) : rc_r;
  assign len_err  = n_rows_r == '0 || int'(n_rows_r) > MAX_ROWS
                    || int'(rc_inc) != int'(n_rows_r);
  assign w_zero   = w_r[j_r] == '0;
  assign j_step   = (j_r == J_LAST) ? '0 : j_r + J_W'(1);

  // stores
  assign u_we = accept && in_cmd == CMD_LOAD_U
                && int'(in_row) < MAX_ROWS && int'(in_col) < NUM_TERMS;
  assign v_we = accept && in_cmd == CMD_LOAD_V
                && int'(in_row) < NUM_TERMS && int'(in_col) < NUM_TERMS;
  assign u_wa_full = 32'(in_row) * 32'(NUM_TERMS) + 32'(in_col);
  assign v_wa_full = 32'(in_row) * 32'(NUM_TERMS) + 32'(in_col);
  assign u_ra_full = 32'(rc_r) * 32'(NUM_TERMS) + 32'(j_r);
  assign v_ra_full = 32'(i_r) * 32'(NUM_TERMS) + 32'(j_r);

  svdbs_ram #(.WIDTH(VAL_W), .DEPTH(U_DEPTH)) u_store (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_wa_full[U_AW-1:0]),
    .wdata (in_value),
    .raddr (u_ra_full[U_AW-1:0]),
    .rdata (u_rdata)
  );

  svdbs_ram #(.WIDTH(VAL_W), .DEPTH(V_DEPTH)) v_store (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_wa_full[V_AW-1:0]),
    .wdata (in_value),
    .raddr (v_ra_full[V_AW-1:0]),
    .rdata (v_rdata)
  );

  svdbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[j_r]),
    .divisor  (w_r[j_r]),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared multiplier and saturating adder
  assign mul_a   = (state_r == S_MAC_MUL) ? u_rdata : v_rdata;
  assign mul_b   = (state_r == S_MAC_MUL) ? b_r : term_r[j_r];
  assign mul_p   = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign add_a   = (state_r == S_MAC_ACC) ? acc_r[j_r] : sum_r;
  assign add_res = sat_add64(add_a, prod_r);

  assign sum_sh = sum_r >>> 16;
  always_comb begin
    if (&sum_sh[ACC_W-1:VAL_W-1] || ~|sum_sh[ACC_W-1:VAL_W-1]) begin
      sum_sat = sum_sh[VAL_W-1:0];
    end else if (sum_sh[ACC_W-1]) begin
      sum_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_b) begin
          state_nxt = do_acc ? S_MAC_RD : S_ROWEND;
        end
      end
      S_MAC_RD:  state_nxt = S_MAC_MUL;
      S_MAC_MUL: state_nxt = S_MAC_ACC;
      S_MAC_ACC: state_nxt = (j_r == J_LAST) ? S_ROWEND : S_MAC_RD;
      S_ROWEND: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (len_err) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_DIV_START;
        end
      end
      S_ERR: state_nxt = S_IDLE;
      S_DIV_START: begin
        if (!w_zero) begin
          state_nxt = S_DIV_WAIT;
        end else if (j_r == J_LAST) begin
          state_nxt = S_V_RD;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (j_r == J_LAST) ? S_V_RD : S_DIV_START;
        end
      end
      S_V_RD:  state_nxt = S_V_MUL;
      S_V_MUL: state_nxt = S_V_ACC;
      S_V_ACC: state_nxt = (j_r == J_LAST) ? S_OUT : S_V_RD;
      S_OUT:   state_nxt = (i_r == J_LAST) ? S_IDLE : S_V_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = state_r != S_IDLE;
    div_start      = state_r == S_DIV_START && !w_zero;
    out_valid      = 1'b0;
    out_term_index = '0;
    out_term_value = '0;
    out_status     = 1'b0;
    out_last_term  = 1'b0;
    case (state_r)
      S_ERR: begin
        out_valid     = 1'b1;
        out_status    = 1'b1;
        out_last_term = 1'b1;
      end
      S_OUT: begin
        out_valid      = 1'b1;
        out_term_index = TIDX_W'(i_r);
        out_term_value = sum_sat;
        out_last_term  = i_r == J_LAST;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_rows_r   <= NROWS_W'(NROWS_RST);
      miss_en_r  <= 1'b0;
      miss_val_r <= '0;
      j_r        <= '0;
      i_r        <= '0;
      rc_r       <= '0;
      last_r     <= 1'b0;
      for (int k = 0; k < NUM_TERMS; k++) begin
        acc_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_N_ROWS:   n_rows_r   <= cfg_data[NROWS_W-1:0];
          REG_MISS_EN:  miss_en_r  <= cfg_data[0];
          REG_MISS_VAL: miss_val_r <= cfg_data[VAL_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept_b) begin
            last_r <= in_last;
            j_r    <= '0;
          end
        end
        S_MAC_ACC: begin
          acc_r[j_r] <= add_res;
          j_r        <= j_step;
        end
        S_ROWEND: begin
          rc_r <= rc_inc;
          j_r  <= '0;
          i_r  <= '0;
        end
        S_ERR: begin
          rc_r <= '0;
          for (int k = 0; k < NUM_TERMS; k++) begin
            acc_r[k] <= '0;
          end
        end
        S_DIV_START: begin
          if (w_zero) begin
            j_r <= j_step;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            j_r <= j_step;
          end
        end
        S_V_ACC: begin
          j_r <= j_step;
        end
        S_OUT: begin
          j_r <= '0;
          if (i_r == J_LAST) begin
            i_r  <= '0;
            rc_r <= '0;
            for (int k = 0; k < NUM_TERMS; k++) begin
              acc_r[k] <= '0;
            end
          end else begin
            i_r <= i_r + J_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD_W && int'(in_col) < NUM_TERMS) begin
      w_r[J_W'(in_col)] <= in_value;
    end
    if (accept_b) begin
      b_r <= in_value;
    end
    prod_r <= mul_p;
    if (state_r == S_DIV_START && w_zero) begin
      term_r[j_r] <= '0;
    end else if (state_r == S_DIV_WAIT && div_done) begin
      term_r[j_r] <= div_q;
    end
    if (state_r == S_V_ACC) begin
      sum_r <= add_res;
    end else if (state_r == S_DIV_START || state_r == S_OUT) begin
      sum_r <= '0;
    end
  end

endmodule

// ===== tb/svd_backsubstitution_solve_unit_test.sv =====
`timescale 1ns / 1ps
// svd_backsubstitution_solve_unit_test: self-checking bench for the svd back-substitution
// solve unit; depends on svdbs_pkg and svd_backsubstitution_solve_unit
// loads U/V/W factors, streams b vectors under several register settings, checks each term

module svd_backsubstitution_solve_unit_test;
  import svdbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES   = 500;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
  } solve_req_t;

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic [VAL_W-1:0]  value;
    logic              status;
    logic              last_term;
  } term_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [COL_W-1:0] in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic [TIDX_W-1:0] out_term_index;
  logic signed [VAL_W-1:0] out_term_value;
  logic out_status;
  logic out_last_term;

  svd_backsubstitution_solve_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_term_index (out_term_index),
    .out_term_value (out_term_value),
    .out_status     (out_status),
    .out_last_term  (out_last_term)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  solve_req_t pending_reqs[$];
  term_res_t  expected_terms[$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         req_taken = 1'b0;
  bit         steady_feed = 1'b0;

  // factor stores, accumulators and register copies of the solver
  logic signed [VAL_W-1:0] u_coef [MAX_ROWS_DEF][NUM_TERMS_DEF];
  logic signed [VAL_W-1:0] v_coef [NUM_TERMS_DEF][NUM_TERMS_DEF];
  logic signed [VAL_W-1:0] w_coef [NUM_TERMS_DEF];
  logic signed [ACC_W-1:0] proj_acc [NUM_TERMS_DEF];
  int                      rows_seen = 0;
  logic [NROWS_W-1:0]      n_rows_reg = NROWS_W'(NROWS_RST);
  bit                      miss_en_reg = 1'b0;
  logic signed [VAL_W-1:0] miss_val_reg = '0;

  function automatic logic signed [ACC_W-1:0] acc_add_sat(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = a + b;
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp32(input logic signed [ACC_W-1:0] x);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[VAL_W-1:0];
  endfunction

  // truncating quotient of a Q32.32 sum by a Q16.16 weight, clamped to 32 bits
  function automatic logic signed [VAL_W-1:0] quot_sat(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] w);
    logic signed [ACC_W-1:0] wl;
    logic [ACC_W-1:0] ma, mw, q;
    logic neg;
    wl = w;
    neg = a[ACC_W-1] ^ w[VAL_W-1];
    ma = a[ACC_W-1] ? -a : a;
    mw = wl[ACC_W-1] ? -wl : wl;
    q = ma / mw;
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return -q[VAL_W-1:0];
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[VAL_W-1:0];
  endfunction

  function automatic void clear_projection();
    for (int j = 0; j < NUM_TERMS_DEF; j++) proj_acc[j] = '0;
    rows_seen = 0;
  endfunction

  task automatic predict_solve(input solve_req_t r);
    logic signed [VAL_W-1:0] bval;
    logic signed [VAL_W-1:0] ut [NUM_TERMS_DEF];
    logic signed [ACC_W-1:0] prod, s;
    term_res_t t;
    bval = r.value;
    case (r.cmd)
      CMD_LOAD_U: u_coef[r.row][r.col] = bval;
      CMD_LOAD_V: if (r.row < NUM_TERMS_DEF) v_coef[r.row][r.col] = bval;
      CMD_LOAD_W: w_coef[r.col] = bval;
      default: begin
        if (!(miss_en_reg && bval == miss_val_reg) && rows_seen < MAX_ROWS_DEF) begin
          for (int j = 0; j < NUM_TERMS_DEF; j++) begin
            prod = u_coef[rows_seen][j] * bval;
            proj_acc[j] = acc_add_sat(proj_acc[j], prod);
          end
        end
        if (rows_seen < MAX_ROWS_DEF + 1) rows_seen++;
        if (r.last) begin
          if (n_rows_reg == 0 || n_rows_reg > MAX_ROWS_DEF || rows_seen != n_rows_reg) begin
            t.idx = '0;
            t.value = '0;
            t.status = 1'b1;
            t.last_term = 1'b1;
            expected_terms.push_back(t);
          end else begin
            for (int j = 0; j < NUM_TERMS_DEF; j++)
              ut[j] = (w_coef[j] == 0) ? '0 : quot_sat(proj_acc[j], w_coef[j]);
            for (int i = 0; i < NUM_TERMS_DEF; i++) begin
              s = '0;
              for (int j = 0; j < NUM_TERMS_DEF; j++) begin
                prod = v_coef[i][j] * ut[j];
                s = acc_add_sat(s, prod);
              end
              t.idx = TIDX_W'(i);
              t.value = clamp32(s >>> 16);
              t.status = 1'b0;
              t.last_term = (i == NUM_TERMS_DEF - 1);
              expected_terms.push_back(t);
            end
          end
          clear_projection();
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (steady_feed) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: one item on the input ports until its transfer
  solve_req_t cur_req = '0;
  bit         driving = 1'b0;
  int         gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (req_taken) begin
        req_taken = 1'b0;
        driving = 1'b0;
        gap_left = pick_gap();
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          driving = 1'b1;
        end
      end
      start    <= driving;
      in_cmd   <= cur_req.cmd;
      in_row   <= cur_req.row;
      in_col   <= cur_req.col;
      in_value <= cur_req.value;
      in_last  <= cur_req.last;
    end
  end

  // monitor: result check, then prediction of the item taken at this edge
  term_res_t want;
  solve_req_t seen_req;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_terms.size() == 0) begin
          flag_mismatch($sformatf("unexpected result idx %0d value %h status %0d last %0d",
                                  out_term_index, out_term_value, out_status, out_last_term));
        end else begin
          want = expected_terms.pop_front();
          if (out_term_index !== want.idx || out_term_value !== want.value ||
              out_status !== want.status || out_last_term !== want.last_term)
            flag_mismatch($sformatf(
              "got idx %0d value %h status %0d last %0d, want idx %0d value %h status %0d last %0d",
              out_term_index, out_term_value, out_status, out_last_term,
              want.idx, want.value, want.status, want.last_term));
        end
      end
      if (start && !busy) begin
        seen_req = '{in_cmd, in_row, in_col, in_value, in_last};
        predict_solve(seen_req);
        req_taken = 1'b1;
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL svd_backsubstitution_solve_unit");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_q();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value,
                          input logic last);
    solve_req_t r;
    r = '{cmd, row, col, value, last};
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_N_ROWS:   n_rows_reg = data[NROWS_W-1:0];
      REG_MISS_EN:  miss_en_reg = data[0];
      REG_MISS_VAL: miss_val_reg = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || driving || start || busy || expected_terms.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_b_vector(input int len, input logic [VAL_W-1:0] mv);
    for (int k = 0; k < len; k++)
      push_req(CMD_B_ELEM, ROW_W'($urandom), COL_W'($urandom),
               ($urandom_range(0, 4) == 0) ? mv : rand_q(), k == len - 1);
  endtask

  // mostly well-formed vectors, with stray loads, lone elements and wrong lengths mixed in
  task automatic fill_phase(input logic [NROWS_W-1:0] nr, input logic [VAL_W-1:0] mv,
                            input int budget);
    int added;
    int len;
    int r;
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    added = 0;
    while (added < budget) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        cmd = CMD_W'($urandom_range(0, 2));
        col = COL_W'($urandom);
        push_req(cmd, ROW_W'($urandom), col,
                 (cmd == CMD_LOAD_W && $urandom_range(0, 4) == 0) ? '0 : rand_q(),
                 1'($urandom));
        added++;
      end else if (r < 17) begin
        push_req(CMD_B_ELEM, ROW_W'($urandom), COL_W'($urandom), rand_q(), 1'($urandom));
        added++;
      end else begin
        len = (nr >= 1 && nr <= MAX_ROWS_DEF) ? int'(nr) : $urandom_range(1, MAX_ROWS_DEF);
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, MAX_ROWS_DEF + 2);
        push_b_vector(len, mv);
        added += len;
      end
    end
  endtask

  logic [NROWS_W-1:0] nr;
  logic               me;
  logic [VAL_W-1:0]   mv;

  initial begin
    clear_projection();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every store entry before any element reads it
    for (int r = 0; r < MAX_ROWS_DEF; r++)
      for (int c = 0; c < NUM_TERMS_DEF; c++)
        push_req(CMD_LOAD_U, ROW_W'(r), COL_W'(c), rand_q(), 1'b0);
    for (int r = 0; r < NUM_TERMS_DEF; r++)
      for (int c = 0; c < NUM_TERMS_DEF; c++)
        push_req(CMD_LOAD_V, ROW_W'(r), COL_W'(c), rand_q(), 1'b0);
    push_req(CMD_LOAD_W, 3'd0, 2'd0, 32'h0001_0000, 1'b0);
    push_req(CMD_LOAD_W, 3'd0, 2'd1, 32'h0000_0000, 1'b0);
    push_req(CMD_LOAD_W, 3'd0, 2'd2, 32'hFFFF_8000, 1'b0);
    push_req(CMD_LOAD_W, 3'd0, 2'd3, 32'h0002_0000, 1'b0);

    // directed: ignored V row, extreme U, tiny w, full/short/long vectors
    push_req(CMD_LOAD_V, 3'd5, 2'd1, 32'h7FFF_FFFF, 1'b1);
    push_req(CMD_LOAD_U, 3'd0, 2'd0, 32'h7FFF_FFFF, 1'b0);
    push_req(CMD_LOAD_U, 3'd0, 2'd1, 32'h8000_0000, 1'b1);
    push_req(CMD_LOAD_W, 3'd7, 2'd3, 32'h0000_0001, 1'b1);
    push_req(CMD_B_ELEM, 3'd7, 2'd3, 32'h8000_0000, 1'b0);
    push_req(CMD_B_ELEM, 3'd0, 2'd0, 32'h7FFF_FFFF, 1'b0);
    push_req(CMD_B_ELEM, 3'd5, 2'd2, 32'h0000_0000, 1'b0);
    push_req(CMD_B_ELEM, 3'd2, 2'd1, 32'hFFFF_FFFF, 1'b0);
    push_req(CMD_B_ELEM, 3'd1, 2'd0, 32'h0000_0001, 1'b0);
    push_req(CMD_B_ELEM, 3'd6, 2'd3, 32'h0001_0000, 1'b0);
    push_req(CMD_B_ELEM, 3'd3, 2'd2, 32'hFFFF_0000, 1'b0);
    push_req(CMD_B_ELEM, 3'd4, 2'd1, rand_q(), 1'b1);
    push_b_vector(3, 32'h0);
    push_b_vector(MAX_ROWS_DEF + 2, 32'h0);
    push_b_vector(1, 32'h0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nr = 4'd8; me = 1'b0; mv = 32'h0; end
        1: begin nr = 4'd1; me = 1'b1; mv = 32'h8000_0000; end
        2: begin nr = NROWS_W'($urandom_range(2, 7)); me = 1'b1; mv = rand_q(); end
        3: begin nr = 4'd0; me = 1'b0; mv = 32'h7FFF_FFFF; end
        4: begin nr = 4'd15; me = 1'b1; mv = 32'h0; end
        5: begin nr = 4'd4; me = 1'b1; mv = 32'h7FFF_FFFF; end
        default: begin
          nr = NROWS_W'($urandom_range(1, 8));
          me = 1'($urandom);
          mv = rand_q();
        end
      endcase
      write_reg(REG_N_ROWS, CFG_DATA_W'(nr));
      write_reg(REG_MISS_EN, CFG_DATA_W'(me));
      write_reg(REG_MISS_VAL, mv);
      steady_feed = (ph % 3 == 1);
      fill_phase(nr, mv, (nr == 0 || nr > MAX_ROWS_DEF) ? 12 : 30);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_terms.size() == 0)
      $display("PASS svd_backsubstitution_solve_unit");
    else
      $display("FAIL svd_backsubstitution_solve_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/svdbs_pkg.sv
rtl/svdbs_ram.sv
rtl/svdbs_div.sv
rtl/svd_backsubstitution_solve_unit.sv
tb/svd_backsubstitution_solve_unit_test.sv
